// ===== sv/vaa_pkg.sv =====
// package: widths, fixed-point constants and pipeline types of the vector angle core
package vaa_pkg;

  // input and output formats
  localparam int unsigned InWidth       = 16;
  localparam int unsigned AngleFracBits = 13;
  localparam int unsigned AngleWidth    = AngleFracBits + 3;

  // quotient a = min / max in Q1.16, widened to Q.30
  localparam int unsigned QuotFrac  = 16;
  localparam int unsigned QuotWidth = QuotFrac + 1;
  localparam int unsigned Qf        = 30;
  localparam int unsigned AWidth    = QuotWidth + Qf - QuotFrac;
  localparam int unsigned RndShift  = Qf - AngleFracBits;

  // polynomial and reflection constants, Q.30
  localparam logic [25:0] KC3     = 26'd49925210;
  localparam logic [27:0] KC2     = 28'd171062341;
  localparam logic [28:0] KC1     = 29'd351782264;
  localparam logic [30:0] KHalfPi = 31'd1686629713;
  localparam logic [31:0] KPi     = 32'd3373259426;

  // octant and special-case flags that ride along the pipeline
  typedef struct packed {
    logic zero;
    logic xneg;
    logic yneg;
    logic swap;
  } flags_t;

  // one stage of the restoring divider
  typedef struct packed {
    flags_t               flags;
    logic [InWidth-1:0]   den;
    logic [InWidth:0]     rem;
    logic [QuotWidth-1:0] quot;
  } div_stage_t;

endpackage

// ===== sv/vector_angle_atan2_core.sv =====
// top level: pipelined atan2 of a signed vector, angle in signed Q2.13 radians
// throughput: one word per cycle unless the output word is held; a 17-stage
//   one-bit-per-stage divider sets the depth, and five multiply stages, a reflect stage
//   and a rounding stage follow it
// a stall at the output freezes every stage at once, so nothing is lost or repeated
// reset: rst_ni asynchronous active low clears all valid bits; data registers are not reset
module vector_angle_atan2_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [vaa_pkg::InWidth-1:0]   x_value_i,
  input  logic signed [vaa_pkg::InWidth-1:0]   y_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [vaa_pkg::AngleWidth-1:0] angle_o
);

  localparam int unsigned W      = vaa_pkg::InWidth;
  localparam int unsigned QW     = vaa_pkg::QuotWidth;
  localparam int unsigned AW     = vaa_pkg::AWidth;
  localparam int unsigned DivN   = QW;            // one quotient bit per stage
  localparam int unsigned NumVld = DivN + 8;      // in, divider, m1..m5, reflect, out

  // global advance: the whole pipeline moves unless the output word is held
  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // valid bits, one per stage
  logic [NumVld-1:0] vld_q, vld_d;

  // ---------------------------------------------------------------- stage 0: magnitudes
  logic [W-1:0]        ax, ay;
  vaa_pkg::div_stage_t div_in;
  vaa_pkg::div_stage_t div_q [DivN+1];
  vaa_pkg::div_stage_t div_d [DivN+1];

  always_comb begin
    // magnitude in W bits: the most negative input maps exactly to 2^(W-1)
    ax = x_value_i[W-1] ? (~x_value_i + W'(1)) : x_value_i;
    ay = y_value_i[W-1] ? (~y_value_i + W'(1)) : y_value_i;
    div_in.flags.zero = (ax == '0) && (ay == '0);
    div_in.flags.xneg = x_value_i[W-1];
    div_in.flags.yneg = y_value_i[W-1];
    div_in.flags.swap = ay > ax;
    div_in.den        = div_in.flags.swap ? ay : ax;
    div_in.rem        = {1'b0, (div_in.flags.swap ? ax : ay)};
    div_in.quot       = '0;
  end

  // ---------------------------------------------------------------- divider steps
  // step 0 tests num >= den for the integer bit, later steps shift the remainder first
  for (genvar k = 0; k < DivN; k++) begin : g_div
    logic [W:0] trial;
    logic       take;
    always_comb begin
      trial = (k == 0) ? div_q[k].rem : {div_q[k].rem[W-1:0], 1'b0};
      take  = trial >= {1'b0, div_q[k].den};
      div_d[k+1].flags = div_q[k].flags;
      div_d[k+1].den   = div_q[k].den;
      div_d[k+1].rem   = take ? (trial - {1'b0, div_q[k].den}) : trial;
      div_d[k+1].quot  = {div_q[k].quot[QW-2:0], take};
    end
  end
  assign div_d[0] = div_in;

  // ---------------------------------------------------------------- polynomial stages
  logic [AW-1:0] a_big;
  assign a_big = {div_q[DivN].quot, (AW-QW)'(0)};

  // m1: s = A*A
  vaa_pkg::flags_t m1_flags_q;
  logic [AW-1:0]   m1_a_q, m1_s_q;
  logic [61:0]     prod_s;
  assign prod_s = 62'(a_big) * 62'(a_big);

  // m2: p1 = c3*s
  vaa_pkg::flags_t m2_flags_q;
  logic [AW-1:0]   m2_a_q, m2_s_q;
  logic [25:0]     m2_p1_q;
  logic [61:0]     prod_p1;
  assign prod_p1 = 62'(vaa_pkg::KC3) * 62'(m1_s_q);

  // m3: p2 = (c2 - p1)*s
  vaa_pkg::flags_t m3_flags_q;
  logic [AW-1:0]   m3_a_q, m3_s_q;
  logic [27:0]     m3_p2_q;
  logic [27:0]     t1;
  logic [61:0]     prod_p2;
  assign t1      = vaa_pkg::KC2 - 28'(m2_p1_q);
  assign prod_p2 = 62'(t1) * 62'(m2_s_q);

  // m4: m3 = (c1 - p2)*s
  vaa_pkg::flags_t m4_flags_q;
  logic [AW-1:0]   m4_a_q;
  logic [28:0]     m4_m3_q;
  logic [28:0]     m2v;
  logic [61:0]     prod_m3;
  assign m2v     = vaa_pkg::KC1 - 29'(m3_p2_q);
  assign prod_m3 = 62'(m2v) * 62'(m3_s_q);

  // m5: m4 = m3*A
  vaa_pkg::flags_t m5_flags_q;
  logic [AW-1:0]   m5_a_q;
  logic [28:0]     m5_m4_q;
  logic [61:0]     prod_m4;
  assign prod_m4 = 62'(m4_m3_q) * 62'(m4_a_q);

  // reflect: first-octant angle into the right octant
  vaa_pkg::flags_t rf_flags_q;
  logic [31:0]     rf_r_q;
  logic [30:0]     r_oct, r_swap;
  logic [31:0]     r_full;
  always_comb begin
    r_oct  = m5_a_q - 31'(m5_m4_q);
    r_swap = m5_flags_q.swap ? (vaa_pkg::KHalfPi - r_oct) : r_oct;
    r_full = m5_flags_q.xneg ? (vaa_pkg::KPi - 32'(r_swap)) : 32'(r_swap);
  end

  // output: round to nearest, ties up, then apply the sign of y; a zero vector gives 0
  logic [32:0]                    rnd_sum;
  logic [vaa_pkg::AngleWidth-1:0] mag, ang_d;
  logic signed [vaa_pkg::AngleWidth-1:0] angle_q;
  always_comb begin
    rnd_sum = 33'(rf_r_q) + (33'(1) << (vaa_pkg::RndShift - 1));
    mag     = rnd_sum[32:vaa_pkg::RndShift];
    if (rf_flags_q.zero) begin
      ang_d = '0;
    end else if (rf_flags_q.yneg) begin
      ang_d = ~mag + vaa_pkg::AngleWidth'(1);
    end else begin
      ang_d = mag;
    end
  end

  // valid chain
  assign vld_d = {vld_q[NumVld-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  // data registers, frozen together with the valid bits
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i <= DivN; i++) begin
        div_q[i] <= div_d[i];
      end
      m1_flags_q <= div_q[DivN].flags;
      m1_a_q     <= a_big;
      m1_s_q     <= prod_s[60:30];

      m2_flags_q <= m1_flags_q;
      m2_a_q     <= m1_a_q;
      m2_s_q     <= m1_s_q;
      m2_p1_q    <= prod_p1[55:30];

      m3_flags_q <= m2_flags_q;
      m3_a_q     <= m2_a_q;
      m3_s_q     <= m2_s_q;
      m3_p2_q    <= prod_p2[57:30];

      m4_flags_q <= m3_flags_q;
      m4_a_q     <= m3_a_q;
      m4_m3_q    <= prod_m3[58:30];

      m5_flags_q <= m4_flags_q;
      m5_a_q     <= m4_a_q;
      m5_m4_q    <= prod_m4[58:30];

      rf_flags_q <= m5_flags_q;
      rf_r_q     <= r_full;

      angle_q    <= ang_d;
    end
  end

  assign out_valid_o = vld_q[NumVld-1];
  assign angle_o     = angle_q;

endmodule
